FILE: hw/rtl/bmdm_pkg.sv
`default_nettype none
package bmdm_pkg;

  // Frame geometry and sample format.
  localparam int MAX_DIM    = 4096;
  localparam int DEPTH_BITS = 16;
  localparam int POS_W      = $clog2(MAX_DIM);
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_DATA_W = 16;

  // Accumulator and result widths.
  localparam int SUM_W     = 40;
  localparam int CNT_W     = 25;
  localparam int MEAN_W    = 24;
  localparam int FRAC_BITS = 8;

  // The divider produces one quotient bit per step.
  localparam int DIV_STEPS = MEAN_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_LEFT     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_TOP      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_RIGHT    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_BOTTOM   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MIN_DEPTH    = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [DEPTH_BITS-1:0] MIN_DEPTH_RST   = 16'd100;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bmdm_if.sv
`default_nettype none
// Sample channel: one depth sample per beat.
interface bmdm_in_if;
  logic                             valid;
  logic                             ready;
  logic [bmdm_pkg::DEPTH_BITS-1:0]  depth_sample;
  logic                             frame_start;

  modport source (output valid, output depth_sample, output frame_start, input ready);
  modport sink   (input valid, input depth_sample, input frame_start, output ready);
endinterface

// Result channel: one frame result per beat.
interface bmdm_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmdm_pkg::MEAN_W-1:0]   mean_depth;
  logic [bmdm_pkg::CNT_W-1:0]    valid_count;

  modport source (output valid, output mean_depth, output valid_count, input ready);
  modport sink   (input valid, input mean_depth, input valid_count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/box_masked_depth_mean.sv
// Samples are taken one per cycle while a frame streams in.
// After the last pixel of a frame the input stalls while the shared
// restoring divider runs (one quotient bit per cycle) and until the
// result register is loaded, which waits until the output is free.
// Synchronous reset clears position, sums and control, and restores the
// register defaults (empty box, 640 x 480 frame, minimum depth 100).
`default_nettype none
module box_masked_depth_mean (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [bmdm_pkg::REG_IDX_W-1:0]        cfg_index,
  input  wire logic [bmdm_pkg::CFG_DATA_W-1:0]       cfg_data,
  bmdm_in_if.sink                                    in_ch,
  bmdm_out_if.source                                 out_ch
);

  localparam int DW  = bmdm_pkg::CFG_DIM_W;
  localparam int PW  = bmdm_pkg::POS_W;

  // Configuration registers.
  logic signed [DW-1:0]             box_left;
  logic signed [DW-1:0]             box_top;
  logic signed [DW-1:0]             box_right;
  logic signed [DW-1:0]             box_bottom;
  logic [DW-1:0]                    frame_width;
  logic [DW-1:0]                    frame_height;
  logic [bmdm_pkg::DEPTH_BITS-1:0]  min_depth;

  // Frame state.
  logic [PW-1:0]                    column_position;
  logic [PW-1:0]                    row_position;
  logic [bmdm_pkg::SUM_W-1:0]       depth_sum;
  logic [bmdm_pkg::CNT_W-1:0]       sample_count;
  logic [bmdm_pkg::CNT_W-1:0]       frame_count;

  // Result register.
  logic                             out_valid;
  logic [bmdm_pkg::MEAN_W-1:0]      mean_reg;
  logic [bmdm_pkg::CNT_W-1:0]       count_reg;

  bmdm_pkg::state_t                 state;
  bmdm_pkg::state_t                 state_next;
  bmdm_pkg::div_req_t               div_req;
  bmdm_pkg::div_stat_t              div_stat;
  logic [bmdm_pkg::MEAN_W-1:0]      quotient;

  logic                             accept;
  logic                             load_out;
  logic                             out_free;
  logic                             in_ready;

  logic [DW-1:0]                    width_c;
  logic [DW-1:0]                    height_c;
  logic [PW-1:0]                    col0;
  logic [PW-1:0]                    row0;
  logic [PW-1:0]                    colw;
  logic [PW-1:0]                    roww;
  logic signed [DW:0]               col_s;
  logic signed [DW:0]               row_s;
  logic                             in_box;
  logic                             qual;
  logic                             col_last;
  logic                             last;
  logic [bmdm_pkg::SUM_W-1:0]       sum_next;
  logic [bmdm_pkg::CNT_W-1:0]       count_next;
  logic [PW-1:0]                    col_next;
  logic [PW-1:0]                    row_next;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_left     <= '0;
      box_top      <= '0;
      box_right    <= '0;
      box_bottom   <= '0;
      frame_width  <= bmdm_pkg::FRAME_WIDTH_RST;
      frame_height <= bmdm_pkg::FRAME_HEIGHT_RST;
      min_depth    <= bmdm_pkg::MIN_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bmdm_pkg::REG_BOX_LEFT:     box_left     <= cfg_data[DW-1:0];
        bmdm_pkg::REG_BOX_TOP:      box_top      <= cfg_data[DW-1:0];
        bmdm_pkg::REG_BOX_RIGHT:    box_right    <= cfg_data[DW-1:0];
        bmdm_pkg::REG_BOX_BOTTOM:   box_bottom   <= cfg_data[DW-1:0];
        bmdm_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[DW-1:0];
        bmdm_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[DW-1:0];
        bmdm_pkg::REG_MIN_DEPTH:    min_depth    <= cfg_data[bmdm_pkg::DEPTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Frame size clamped to the supported range; zero is taken as one.
  always_comb begin
    if (frame_width == '0) begin
      width_c = DW'(1);
    end else if (frame_width > DW'(bmdm_pkg::MAX_DIM)) begin
      width_c = DW'(bmdm_pkg::MAX_DIM);
    end else begin
      width_c = frame_width;
    end
    if (frame_height == '0) begin
      height_c = DW'(1);
    end else if (frame_height > DW'(bmdm_pkg::MAX_DIM)) begin
      height_c = DW'(bmdm_pkg::MAX_DIM);
    end else begin
      height_c = frame_height;
    end
  end

  // Per-sample position, box test and accumulation.
  always_comb begin
    col0 = in_ch.frame_start ? '0 : column_position;
    row0 = in_ch.frame_start ? '0 : row_position;
    colw = (DW'(col0) >= width_c)  ? '0 : col0;
    roww = (DW'(row0) >= height_c) ? '0 : row0;

    col_s  = signed'((DW + 1)'(colw));
    row_s  = signed'((DW + 1)'(roww));
    in_box = (col_s >= signed'({box_left[DW-1], box_left})) &&
             (col_s <  signed'({box_right[DW-1], box_right})) &&
             (row_s >= signed'({box_top[DW-1], box_top})) &&
             (row_s <  signed'({box_bottom[DW-1], box_bottom}));
    qual   = in_box && (in_ch.depth_sample > min_depth);

    sum_next   = (in_ch.frame_start ? '0 : depth_sum) +
                 (qual ? bmdm_pkg::SUM_W'(in_ch.depth_sample) : '0);
    count_next = (in_ch.frame_start ? '0 : sample_count) +
                 bmdm_pkg::CNT_W'(qual);

    col_last = DW'(colw) == (width_c - 1'b1);
    last     = col_last && (DW'(roww) == (height_c - 1'b1));
    col_next = col_last ? '0 : colw + 1'b1;
    row_next = col_last ? roww + 1'b1 : roww;
  end

  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid || out_ch.ready;

  // Sequencer: stream samples, divide once per frame, then hand off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmdm_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      bmdm_pkg::ST_RUN: begin
        in_ready = 1'b1;
        if (in_ch.valid && last) begin
          state_next = bmdm_pkg::ST_DIV;
        end
      end
      bmdm_pkg::ST_DIV: begin
        if (div_stat.done) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = bmdm_pkg::ST_RUN;
          end else begin
            state_next = bmdm_pkg::ST_HOLD;
          end
        end
      end
      bmdm_pkg::ST_HOLD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = bmdm_pkg::ST_RUN;
        end
      end
      default: state_next = bmdm_pkg::ST_RUN;
    endcase
  end

  assign in_ch.ready = in_ready;

  // Accumulators and position; cleared after the last pixel of a frame and restarted by a start mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      depth_sum       <= '0;
      sample_count    <= '0;
    end else if (accept) begin
      if (last) begin
        column_position <= '0;
        row_position    <= '0;
        depth_sum       <= '0;
        sample_count    <= '0;
      end else begin
        column_position <= col_next;
        row_position    <= row_next;
        depth_sum       <= sum_next;
        sample_count    <= count_next;
      end
    end
  end

  // Count of the frame being divided.
  always_ff @(posedge clk) begin
    if (accept && last) begin
      frame_count <= count_next;
    end
  end

  assign div_req.start = accept && last;
  assign div_req.sum   = sum_next;
  assign div_req.count = count_next;

  bmdm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Result register; mean is zero when nothing qualified.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      mean_reg  <= (frame_count == '0) ? '0 : quotient;
      count_reg <= frame_count;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.mean_depth  = mean_reg;
  assign out_ch.valid_count = count_reg;

  // The last pixel of a frame starts the divider.
  a_last_starts_div: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> div_stat.busy)
    else $error("divider not started after last pixel");

  // No sample is taken while the divider is running.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !in_ch.ready)
    else $error("input ready while divider busy");

  // The result register is loaded only after the divider has finished.
  a_load_after_div: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !div_stat.busy && out_free)
    else $error("result loaded while divider busy or output full");

  // An empty count always gives a zero mean.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && count_reg == '0) |-> mean_reg == '0)
    else $error("nonzero mean with zero count");

endmodule
`default_nettype wire

FILE: hw/rtl/bmdm_div.sv
`default_nettype none
// Restoring divider: (sum << FRAC_BITS) / count, one quotient bit per cycle.
// The quotient is known to fit MEAN_W bits, so the upper dividend bits seed
// the partial remainder and only MEAN_W steps are needed.
module bmdm_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bmdm_pkg::div_req_t                 req,
  output bmdm_pkg::div_stat_t                     stat,
  output logic [bmdm_pkg::MEAN_W-1:0]             quotient
);

  localparam int DVD_W = bmdm_pkg::SUM_W + bmdm_pkg::FRAC_BITS;

  logic [DVD_W-1:0]                 dividend;
  logic [bmdm_pkg::CNT_W-1:0]       rem;
  logic [bmdm_pkg::CNT_W-1:0]       divisor;
  logic [bmdm_pkg::MEAN_W-1:0]      quo;
  logic [bmdm_pkg::STEP_W-1:0]      step;
  logic                             busy;
  logic                             done;
  logic [bmdm_pkg::CNT_W:0]         shifted;
  logic [bmdm_pkg::CNT_W:0]         diff;
  logic                             fits;

  assign dividend = {req.sum, {bmdm_pkg::FRAC_BITS{1'b0}}};

  // Shared subtract and compare: one trial subtraction per step.
  always_comb begin
    shifted = {rem, quo[bmdm_pkg::MEAN_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= bmdm_pkg::STEP_W'(bmdm_pkg::DIV_STEPS);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == bmdm_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= bmdm_pkg::CNT_W'(dividend[DVD_W-1:bmdm_pkg::MEAN_W]);
      quo     <= dividend[bmdm_pkg::MEAN_W-1:0];
      divisor <= req.count;
    end else if (busy) begin
      rem <= fits ? diff[bmdm_pkg::CNT_W-1:0] : shifted[bmdm_pkg::CNT_W-1:0];
      quo <= {quo[bmdm_pkg::MEAN_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule
`default_nettype wire

FILE: verif/box_masked_depth_mean_test.sv
`default_nettype none
module box_masked_depth_mean_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bmdm_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 420;
  localparam int MAX_GAP      = 12;

  localparam logic signed [CFG_DIM_W-1:0] EDGE_MIN = 13'h1000;
  localparam logic signed [CFG_DIM_W-1:0] EDGE_MAX = 13'h0FFF;
  localparam logic [7:0] ALL_REGS = 8'hFF;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]  count;
  } frame_result_t;

  typedef struct {
    logic signed [CFG_DIM_W-1:0] left;
    logic signed [CFG_DIM_W-1:0] top;
    logic signed [CFG_DIM_W-1:0] right;
    logic signed [CFG_DIM_W-1:0] bottom;
    logic [CFG_DIM_W-1:0]        width;
    logic [CFG_DIM_W-1:0]        height;
    logic [DEPTH_BITS-1:0]       min_depth;
  } roi_settings_t;

  // Tracks the configuration registers and the frame accumulation, and holds the
  // frame results that are still due on the result channel.
  class roi_mean_board;
    logic signed [CFG_DIM_W-1:0] box_left, box_top, box_right, box_bottom;
    logic [CFG_DIM_W-1:0]        frame_width, frame_height;
    logic [DEPTH_BITS-1:0]       min_depth;
    int unsigned                 col, row;
    logic [SUM_W-1:0]            depth_sum;
    logic [CNT_W-1:0]            hit_count;
    frame_result_t               results_due[$];
    int                          errors;

    function new();
      box_left = '0;
      box_top = '0;
      box_right = '0;
      box_bottom = '0;
      frame_width = FRAME_WIDTH_RST;
      frame_height = FRAME_HEIGHT_RST;
      min_depth = MIN_DEPTH_RST;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      col = 0;
      row = 0;
      depth_sum = '0;
      hit_count = '0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BOX_LEFT:     box_left = data[CFG_DIM_W-1:0];
        REG_BOX_TOP:      box_top = data[CFG_DIM_W-1:0];
        REG_BOX_RIGHT:    box_right = data[CFG_DIM_W-1:0];
        REG_BOX_BOTTOM:   box_bottom = data[CFG_DIM_W-1:0];
        REG_FRAME_WIDTH:  frame_width = data[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height = data[CFG_DIM_W-1:0];
        REG_MIN_DEPTH:    min_depth = data[DEPTH_BITS-1:0];
        default: ;
      endcase
    endfunction

    // A frame size of zero acts as one, anything past the largest size as
    // the largest size.
    function int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void note_beat(logic [DEPTH_BITS-1:0] depth, logic start);
      int unsigned w, h;
      bit in_box;
      logic [SUM_W+FRAC_BITS-1:0] scaled;
      frame_result_t res;
      w = clamp_dim(frame_width);
      h = clamp_dim(frame_height);
      if (start) clear_frame();
      // A frame that shrank under the current position wraps to its origin.
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      in_box = int'(col) >= int'(box_left) && int'(col) < int'(box_right) &&
               int'(row) >= int'(box_top) && int'(row) < int'(box_bottom);
      if (in_box && depth > min_depth) begin
        depth_sum = depth_sum + depth;
        hit_count = hit_count + 1'b1;
      end
      if (col == w - 1 && row == h - 1) begin
        res.count = hit_count;
        res.mean = '0;
        if (hit_count != 0) begin
          scaled = {depth_sum, {FRAC_BITS{1'b0}}};
          scaled = scaled / hit_count;
          res.mean = scaled[MEAN_W-1:0];
        end
        results_due = {results_due, res};
        clear_frame();
      end else if (col == w - 1) begin
        col = 0;
        row++;
      end else begin
        col++;
      end
    endfunction

    function void check_result(logic [MEAN_W-1:0] mean, logic [CNT_W-1:0] count);
      frame_result_t want;
      if (results_due.size() == 0) begin
        $error("unexpected result: mean_depth %0d, valid_count %0d", mean, count);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (mean !== want.mean) begin
        $error("mean_depth: expected %0d, actual %0d", want.mean, mean);
        errors++;
      end
      if (count !== want.count) begin
        $error("valid_count: expected %0d, actual %0d", want.count, count);
        errors++;
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_we;
  logic [REG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  bit                      no_idle = 1'b1;
  int                      quiet_cycles = 0;
  roi_mean_board           board = new();

  bmdm_in_if  depth_ch ();
  bmdm_out_if mean_ch ();

  box_masked_depth_mean uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (depth_ch),
    .out_ch    (mean_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every accepted beat on either channel goes to the board.
  always @(posedge clk) begin
    if (!rst && depth_ch.valid && depth_ch.ready) begin
      board.note_beat(depth_ch.depth_sample, depth_ch.frame_start);
    end
    if (!rst && mean_ch.valid && mean_ch.ready) begin
      board.check_result(mean_ch.mean_depth, mean_ch.valid_count);
    end
  end

  // The run is stuck once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || cfg_we || (depth_ch.valid && depth_ch.ready) ||
        (mean_ch.valid && mean_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("box_masked_depth_mean_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: after each beat draw a stall, which starts counting once
  // the next result shows up.
  initial begin
    int stall;
    mean_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        mean_ch.ready <= 1'b0;
        do @(posedge clk); while (mean_ch.valid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
      end
      mean_ch.ready <= 1'b1;
      do @(posedge clk); while (!(mean_ch.valid === 1'b1 && mean_ch.ready === 1'b1));
    end
  end

  task automatic send_depth(input logic [DEPTH_BITS-1:0] depth, input logic start);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      depth_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    depth_ch.valid <= 1'b1;
    depth_ch.depth_sample <= depth;
    depth_ch.frame_start <= start;
    do @(posedge clk); while (depth_ch.ready !== 1'b1);
  endtask

  // Wait for every due result, then let the divider run dry.
  task automatic settle();
    depth_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  // The 13-bit registers get random junk in the unused upper bits.
  task automatic load_settings(input roi_settings_t s, input logic [7:0] mask);
    if (mask[REG_BOX_LEFT]) write_reg(REG_BOX_LEFT, {3'($urandom), s.left});
    if (mask[REG_BOX_TOP]) write_reg(REG_BOX_TOP, {3'($urandom), s.top});
    if (mask[REG_BOX_RIGHT]) write_reg(REG_BOX_RIGHT, {3'($urandom), s.right});
    if (mask[REG_BOX_BOTTOM]) write_reg(REG_BOX_BOTTOM, {3'($urandom), s.bottom});
    if (mask[REG_FRAME_WIDTH]) write_reg(REG_FRAME_WIDTH, {3'($urandom), s.width});
    if (mask[REG_FRAME_HEIGHT]) write_reg(REG_FRAME_HEIGHT, {3'($urandom), s.height});
    if (mask[REG_MIN_DEPTH]) write_reg(REG_MIN_DEPTH, s.min_depth);
    cfg_we <= 1'b0;
  endtask

  // Depth values cluster on no reading, full scale and the threshold itself.
  function automatic logic [DEPTH_BITS-1:0] pick_depth(logic [DEPTH_BITS-1:0] floor_mm);
    int near;
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return '1;
      3, 4: begin
        near = int'(floor_mm) + int'($urandom_range(0, 2)) - 1;
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        return DEPTH_BITS'(near);
      end
      default: return DEPTH_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [CFG_DIM_W-1:0] pick_edge(int lo, int hi);
    case ($urandom_range(0, 11))
      0: return EDGE_MIN;
      1: return EDGE_MAX;
      default: return CFG_DIM_W'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  // Small frames so that results come often; the box wanders around them.
  function automatic roi_settings_t random_settings();
    roi_settings_t s;
    int w, h;
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 5);
    s.width = ($urandom_range(0, 15) == 0) ? '0 : CFG_DIM_W'(w);
    s.height = ($urandom_range(0, 15) == 0) ? '0 : CFG_DIM_W'(h);
    s.left = pick_edge(-2, w);
    s.right = pick_edge(0, w + 2);
    s.top = pick_edge(-2, h);
    s.bottom = pick_edge(0, h + 2);
    case ($urandom_range(0, 5))
      0: s.min_depth = '0;
      1: s.min_depth = '1;
      2: s.min_depth = MIN_DEPTH_RST;
      default: s.min_depth = DEPTH_BITS'($urandom);
    endcase
    return s;
  endfunction

  initial begin
    roi_settings_t s;
    logic [DEPTH_BITS-1:0] tail[6] = '{16'd0, 16'd1, 16'd0, 16'd0, 16'd2, 16'd0};
    int count, sent;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    depth_ch.valid <= 1'b0;
    depth_ch.depth_sample <= '0;
    depth_ch.frame_start <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: one row at the default width, default threshold, box
    // from the default origin. Partway through, the row is cut to ten
    // pixels so that the frame ends soon.
    s.right = EDGE_MAX;
    s.bottom = 13'sd1;
    s.height = 13'd1;
    load_settings(s, (8'd1 << REG_BOX_RIGHT) | (8'd1 << REG_BOX_BOTTOM) |
                     (8'd1 << REG_FRAME_HEIGHT));
    for (int i = 0; i < 8; i++) send_depth(pick_depth(MIN_DEPTH_RST), i == 0);
    settle();
    s.width = 13'd10;
    load_settings(s, 8'd1 << REG_FRAME_WIDTH);
    for (int i = 0; i < 2; i++) send_depth(pick_depth(MIN_DEPTH_RST), 1'b0);
    settle();
    no_idle = 1'b0;

    // Whole 3 x 2 frame in the box: an aborted frame, a restart at full
    // scale, then a frame that follows without a start mark.
    s = '{left: 13'sd0, top: 13'sd0, right: 13'sd3, bottom: 13'sd2,
          width: 13'd3, height: 13'd2, min_depth: 16'd0};
    load_settings(s, ALL_REGS);
    send_depth(16'd7, 1'b1);
    send_depth(16'd9, 1'b0);
    for (int i = 0; i < 6; i++) send_depth('1, i == 0);
    foreach (tail[i]) send_depth(tail[i], 1'b0);
    settle();

    // Inverted box: nothing qualifies.
    s = '{left: 13'sd5, top: 13'sd0, right: 13'sd2, bottom: 13'sd1,
          width: 13'd2, height: 13'd1, min_depth: 16'd0};
    load_settings(s, ALL_REGS);
    send_depth('1, 1'b1);
    send_depth('1, 1'b0);
    settle();

    // Box far past the frame on all sides, threshold at full scale.
    s = '{left: EDGE_MIN, top: EDGE_MIN, right: EDGE_MAX, bottom: EDGE_MAX,
          width: 13'd2, height: 13'd1, min_depth: '1};
    load_settings(s, ALL_REGS);
    send_depth('1, 1'b0);
    send_depth('1, 1'b0);
    settle();

    // Zero frame size acts as a single pixel: one result per beat.
    s.width = '0;
    s.height = '0;
    s.min_depth = 16'hFFFE;
    load_settings(s, ALL_REGS);
    send_depth('1, 1'b0);
    send_depth(16'hFFFE, 1'b0);
    settle();

    // Width past the largest size clamps to it; a few beats run at that
    // size before the next settings shrink the frame under them.
    s = '{left: 13'sd4000, top: -13'sd5, right: EDGE_MAX, bottom: 13'sd3,
          width: 13'h1FFF, height: 13'd1, min_depth: 16'd0};
    load_settings(s, ALL_REGS);
    no_idle = 1'b1;
    for (int i = 0; i < 6; i++) send_depth(pick_depth(16'd0), i == 0);
    settle();

    // Random phases; a phase often ends mid-frame, so new settings land
    // inside a frame.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      s = random_settings();
      load_settings(s, ALL_REGS);
      no_idle = ($urandom_range(0, 3) == 0);
      count = $urandom_range(10, 35);
      for (int i = 0; i < count; i++) begin
        send_depth(pick_depth(s.min_depth),
                   (i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 19) == 0);
      end
      sent += count;
      settle();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("box_masked_depth_mean_test: done, clean");
    end else begin
      $display("box_masked_depth_mean_test: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
